// ===== rtl/acot_pkg.sv =====
// Shared types, constants and elaboration-time angle tables for the arccotangent unit.
// Used by acot_stage and arccotangent_fixed_point; depends on nothing else.
package acot_pkg;

    localparam int GUARD_BITS = 28;
    localparam int ANG_FRAC   = 60;
    localparam int XY_W       = 62;   // |X|,|Y| stay below 2^60 for every input
    localparam int Z_W        = 64;   // Q4.60 angle accumulator
    localparam logic [31:0] ANGLE_MAX = 32'd3373259426;

    typedef struct packed {
        logic vld;
        logic zero;   // argument was exactly zero
    } t_ctl;

    // Divide by the k-th odd number, literal divisors only.
    function automatic logic [63:0] odd_div(input logic [63:0] v, input int unsigned k);
        logic [63:0] r;
        case (k)
            0:  r = v;
            1:  r = v / 64'd3;
            2:  r = v / 64'd5;
            3:  r = v / 64'd7;
            4:  r = v / 64'd9;
            5:  r = v / 64'd11;
            6:  r = v / 64'd13;
            7:  r = v / 64'd15;
            8:  r = v / 64'd17;
            9:  r = v / 64'd19;
            10: r = v / 64'd21;
            11: r = v / 64'd23;
            12: r = v / 64'd25;
            13: r = v / 64'd27;
            14: r = v / 64'd29;
            15: r = v / 64'd31;
            16: r = v / 64'd33;
            17: r = v / 64'd35;
            18: r = v / 64'd37;
            19: r = v / 64'd39;
            20: r = v / 64'd41;
            21: r = v / 64'd43;
            22: r = v / 64'd45;
            23: r = v / 64'd47;
            24: r = v / 64'd49;
            25: r = v / 64'd51;
            26: r = v / 64'd53;
            27: r = v / 64'd55;
            28: r = v / 64'd57;
            29: r = v / 64'd59;
            default: r = '0;
        endcase
        return r;
    endfunction

    // atan(1/5) or atan(1/239) in Q4.60, truncated power series.
    function automatic logic [63:0] atan_recip(input bit use239);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] term;
        int unsigned k;
        p   = use239 ? ((64'd1 << ANG_FRAC) / 64'd239) : ((64'd1 << ANG_FRAC) / 64'd5);
        sum = '0;
        for (k = 0; k < 64; k++) begin
            if (p != 64'd0) begin
                term = odd_div(p, k);
                if (k[0]) sum = sum - term;
                else sum = sum + term;
                p = use239 ? (p / 64'd57121) : (p / 64'd25);
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] quarter_pi();
        return (64'd4 * atan_recip(1'b0)) - atan_recip(1'b1);
    endfunction

    // atan(2^-i) in Q4.60.
    function automatic logic [63:0] atan_pow2(input int unsigned i);
        logic [63:0] sum;
        logic [63:0] term;
        int unsigned k;
        int unsigned e;
        bit done;
        sum  = '0;
        done = 1'b0;
        if (i == 0) begin
            sum = quarter_pi();
        end else begin
            for (k = 0; k < 64; k++) begin
                e = i * (2 * k + 1);
                if (e > ANG_FRAC) done = 1'b1;
                if (!done) begin
                    term = odd_div(64'd1 << (ANG_FRAC - e), k);
                    if (k[0]) sum = sum - term;
                    else sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    // Round Q4.60 to Q2.30, clamp to [0, pi].
    function automatic logic [31:0] round_q30(input logic [Z_W-1:0] z);
        logic [Z_W-1:0] s;
        logic [Z_W-31:0] r;
        logic [31:0] q;
        s = z + (Z_W'(1) << (ANG_FRAC - 31));
        r = s[Z_W-1:ANG_FRAC-30];
        if (z[Z_W-1]) q = '0;
        else if (r > (Z_W-30)'(ANGLE_MAX)) q = ANGLE_MAX;
        else q = r[31:0];
        return q;
    endfunction

    localparam logic [Z_W-1:0] PI_HALF_Q60 = Z_W'(64'd2 * quarter_pi());
    localparam logic [31:0]    PI_HALF_Q30 = round_q30(PI_HALF_Q60);

endpackage

// ===== rtl/acot_stage.sv =====
// One CORDIC vectoring micro-rotation with its pipeline register and bubble-filling ready.
// Depends on acot_pkg for widths, t_ctl and the atan(2^-i) table function.
module acot_stage
    import acot_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl                  i_ctl,
    input  logic signed [XY_W-1:0] i_x,
    input  logic signed [XY_W-1:0] i_y,
    input  logic [Z_W-1:0]        i_z,
    input  logic                  i_ready,
    output logic                  o_ready,
    output t_ctl                  o_ctl,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [XY_W-1:0] o_y,
    output logic [Z_W-1:0]        o_z
);

    localparam logic [Z_W-1:0] ANG = Z_W'(atan_pow2(STAGE));

    t_ctl                   r_ctl;
    logic signed [XY_W-1:0] r_x, r_y;
    logic [Z_W-1:0]         r_z;
    logic signed [XY_W-1:0] n_x, n_y;
    logic [Z_W-1:0]         n_z;
    logic signed [XY_W-1:0] xs, ys;

    assign o_ready = !r_ctl.vld || i_ready;

    always_comb begin
        xs = i_x >>> STAGE;
        ys = i_y >>> STAGE;
        // rotate toward the X axis: direction from the sign of Y
        if (!i_y[XY_W-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ANG;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.vld <= 1'b0;
        end else if (o_ready) begin
            r_ctl.vld <= i_ctl.vld;
        end
        if (o_ready && i_ctl.vld) begin
            r_ctl.zero <= i_ctl.zero;
            r_x        <= n_x;
            r_y        <= n_y;
            r_z        <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

// ===== rtl/arccotangent_fixed_point.sv =====
// Top level of the pipelined fixed-point arccotangent unit.
// Depends on acot_pkg and instantiates acot_stage once per micro-rotation.
//
// Usage:
//   Input channel:  i_valid / o_stall carry i_x_value, a signed Q16.16 argument
//                   (INPUT_FRAC_BITS fraction bits). A request is taken at a rising
//                   edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall carry o_angle, arccot(x) in radians as
//                   unsigned Q2.30 in (0, pi]. A request leaves at an edge with
//                   o_valid high and i_stall low.
//   The path holds one entry register, one register per micro-rotation and one
//   rounding register. Throughput: one request per cycle while i_stall is low,
//   set by the single shift-add rotation in each pipeline stage.
//   A zero argument returns pi/2 exactly.
//   Reset (i_rst_n low, synchronous) empties the pipeline; no results survive.
//   When the receiver stalls, the output holds and each stage keeps its request;
//   empty stages upstream still fill, so o_stall rises only once every stage
//   holds a request.
module arccotangent_fixed_point
    import acot_pkg::*;
#(
    parameter int CORDIC_STAGES   = 32,
    parameter int INPUT_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_x_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_angle
);

    localparam logic signed [XY_W-1:0] X_INIT =
        XY_W'(1) <<< (INPUT_FRAC_BITS + GUARD_BITS);

    t_ctl                   ctl [0:CORDIC_STAGES];
    logic signed [XY_W-1:0] sx  [0:CORDIC_STAGES];
    logic signed [XY_W-1:0] sy  [0:CORDIC_STAGES];
    logic [Z_W-1:0]         sz  [0:CORDIC_STAGES];
    logic                   rdy [0:CORDIC_STAGES];

    t_ctl                   r_in_ctl;
    logic signed [XY_W-1:0] r_in_x, r_in_y;
    logic                   in_ready;
    logic signed [XY_W-1:0] x_ext;
    logic signed [XY_W-1:0] n_in_y;

    logic                   r_out_vld;
    logic                   r_out_zero;
    logic [31:0]            r_angle;
    logic                   out_ready;
    logic [31:0]            n_angle;

    // entry stage: form the vector (1, -x)
    assign in_ready = !r_in_ctl.vld || rdy[0];
    assign o_stall  = !in_ready;
    assign x_ext    = XY_W'(signed'(i_x_value));
    assign n_in_y   = (-x_ext) <<< GUARD_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl.vld <= 1'b0;
        end else if (in_ready) begin
            r_in_ctl.vld <= i_valid;
        end
        if (in_ready && i_valid) begin
            r_in_ctl.zero <= (i_x_value == 32'd0);
            r_in_x        <= X_INIT;
            r_in_y        <= n_in_y;
        end
    end

    assign ctl[0] = r_in_ctl;
    assign sx[0]  = r_in_x;
    assign sy[0]  = r_in_y;
    assign sz[0]  = PI_HALF_Q60;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        acot_stage #(
            .STAGE(k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[k]),
            .i_x     (sx[k]),
            .i_y     (sy[k]),
            .i_z     (sz[k]),
            .i_ready (rdy[k+1]),
            .o_ready (rdy[k]),
            .o_ctl   (ctl[k+1]),
            .o_x     (sx[k+1]),
            .o_y     (sy[k+1]),
            .o_z     (sz[k+1])
        );
    end

    // output stage: round, clamp, and substitute pi/2 for a zero argument
    assign out_ready            = !r_out_vld || !i_stall;
    assign rdy[CORDIC_STAGES]   = out_ready;
    assign n_angle = ctl[CORDIC_STAGES].zero ? PI_HALF_Q30 : round_q30(sz[CORDIC_STAGES]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_ready) begin
            r_out_vld <= ctl[CORDIC_STAGES].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && ctl[CORDIC_STAGES].vld) begin
            r_angle    <= n_angle;
            r_out_zero <= ctl[CORDIC_STAGES].zero;
        end
    end

    assign o_valid = r_out_vld;
    assign o_angle = r_angle;

`ifndef SYNTH
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_in_ctl.vld)
        else $error("accepted request did not enter the pipeline");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle <= ANGLE_MAX))
        else $error("angle above pi");

    a_zero_half_pi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_zero) |-> (o_angle == PI_HALF_Q30))
        else $error("zero argument did not give pi/2");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_ctl.vld && r_out_vld && i_stall))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

// ===== verif/arccotangent_fixed_point_tb.sv =====
// Testbench for arccotangent_fixed_point: drives signed Q16.16 arguments and checks every
// Q2.30 angle against a built-in CORDIC predictor. Depends on the RTL top level only.
`timescale 1ns / 1ps

module arccotangent_fixed_point_tb;

    localparam int          STAGES       = 32;
    localparam int          FRAC_BITS    = 16;
    localparam int          GUARD        = 28;
    localparam int          ANGLE_FRAC   = 60;
    localparam bit [31:0]   PI_Q30       = 32'd3373259426;
    localparam int          MAX_WAIT     = 14;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          FLUSH_CYCLES = STAGES + 8;
    localparam int unsigned STUCK_LIMIT  = 3000;

    typedef struct {
        bit [31:0] x;
        bit [31:0] angle;
    } t_angle_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_x_value;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_angle;

    t_angle_req  pending_angles[$];
    bit [63:0]   micro_angle [0:STAGES-1];
    bit [63:0]   half_pi_q60;
    int          error_count = 0;
    bit          send_idle_on;
    bit          recv_idle_on;
    bit          hold_req;
    bit          hold_seen = 1'b0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned stuck_cycles = 0;

    arccotangent_fixed_point uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_x_value(i_x_value),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_angle  (o_angle)
    );

    always #5 i_clk = ~i_clk;

    // atan(1/n) in Q4.60, truncated alternating power series
    function automatic bit [63:0] atan_recip_series(input bit [63:0] n);
        bit [63:0] p;
        bit [63:0] sum;
        bit [63:0] term;
        bit [63:0] k;
        p   = (64'd1 << ANGLE_FRAC) / n;
        sum = '0;
        k   = '0;
        while (p != 0 && k < 64) begin
            term = p / (2 * k + 1);
            if (k[0]) sum = sum - term;
            else sum = sum + term;
            p = p / (n * n);
            k = k + 1;
        end
        return sum;
    endfunction

    function automatic bit [31:0] q60_to_q30(input bit [63:0] z);
        bit [63:0] r;
        if (z[63]) return '0;
        r = (z + (64'd1 << (ANGLE_FRAC - 31))) >> (ANGLE_FRAC - 30);
        if (r > 64'(PI_Q30)) return PI_Q30;
        return r[31:0];
    endfunction

    // Vector (1, -x) rotated onto the X axis, angles accumulated on top of pi/2
    function automatic bit [31:0] predict_arccot(input bit [31:0] x);
        bit signed [63:0] xr;
        bit signed [63:0] yr;
        bit signed [63:0] xs;
        bit signed [63:0] ys;
        bit signed [63:0] xe;
        bit [63:0]        z;
        z = half_pi_q60;
        if (x == 0) return q60_to_q30(z);
        xe = $signed(x);
        xr = 64'sd1 <<< (FRAC_BITS + GUARD);
        yr = (-xe) <<< GUARD;
        for (int i = 0; i < STAGES; i++) begin
            xs = xr >>> i;
            ys = yr >>> i;
            if (yr >= 0) begin
                xr = xr + ys;
                yr = yr - xs;
                z  = z + micro_angle[i];
            end else begin
                xr = xr - ys;
                yr = yr + xs;
                z  = z - micro_angle[i];
            end
        end
        return q60_to_q30(z);
    endfunction

    function automatic bit [31:0] random_x();
        bit [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h0003_FFFF);
            2: v = $urandom_range(1, 255);
            3: v = 32'd1 << $urandom_range(0, 30);
            default: v = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    // Leaves i_valid high on return so back-to-back requests need no second drive
    task automatic send_x(input bit [31:0] x);
        int unsigned gap;
        gap = send_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_value <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_angles.push_back('{x: x, angle: predict_arccot(x)});
    endtask

    task automatic wait_drained(input int unsigned extra);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic test_corner_arguments();
        bit [31:0] corner_x [0:19];
        corner_x = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_FFFF,
                     32'hFFFF_0001, 32'h0000_0002, 32'h4000_0000, 32'hC000_0000,
                     32'h7FFF_0000, 32'h8001_0000, 32'h0001_BB68, 32'hFFFE_4498,
                     32'h0000_93CD, 32'hFFFF_6C33, 32'h5555_5555, 32'hAAAA_AAAA};
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        foreach (corner_x[i]) send_x(corner_x[i]);
        wait_drained(0);
    endtask

    task automatic test_random_arguments();
        for (int blk = 0; blk < 9; blk++) begin
            // first block idles on both sides, later ones mix idle and full-rate sides
            send_idle_on = (blk == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            recv_idle_on = (blk == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            repeat (100) send_x(random_x());
        end
        wait_drained(0);
    endtask

    task automatic test_full_rate();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        repeat (60) send_x(random_x());
        wait_drained(0);
    endtask

    task automatic test_output_backpressure();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b1;
        hold_req     = 1'b1;
        repeat (70) send_x(random_x());
    endtask

    // Result side: stall control and comparison against the oldest expectation
    always @(posedge i_clk) begin
        t_angle_req want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_angles.size() == 0) begin
                    $display("%0t: unexpected angle %0d with no request pending", $time, o_angle);
                    error_count++;
                end else begin
                    want = pending_angles.pop_front();
                    if (o_angle !== want.angle) begin
                        $display("%0t: angle mismatch for x=%h: expected %0d, actual %0d",
                                 $time, want.x, want.angle, o_angle);
                        error_count++;
                    end
                end
                stall_left = recv_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            end
            // start the long hold once, on the first request from the test sequence
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) stuck_cycles = 0;
            else stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, stuck_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        bit [63:0] quarter_q60;
        bit [63:0] sum;
        bit [63:0] term;
        int        e;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_x_value    = '0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        hold_req     = 1'b0;

        // pi/4 by Machin's formula, atan(2^-i) by its own series
        quarter_q60    = 64'd4 * atan_recip_series(64'd5) - atan_recip_series(64'd239);
        half_pi_q60    = 64'd2 * quarter_q60;
        micro_angle[0] = quarter_q60;
        for (int i = 1; i < STAGES; i++) begin
            sum = '0;
            for (int k = 0; k < 64; k++) begin
                e = i * (2 * k + 1);
                if (e > ANGLE_FRAC) break;
                term = (64'd1 << (ANGLE_FRAC - e)) / 64'(2 * k + 1);
                if (k % 2 == 1) sum = sum - term;
                else sum = sum + term;
            end
            micro_angle[i] = sum;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_arguments();
        test_random_arguments();
        test_full_rate();
        test_output_backpressure();
        wait_drained(FLUSH_CYCLES);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
